[rtl/qat_pkg.sv]
package qat_pkg;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_SINGLE = 2'd1,
    QM_DOUBLE = 2'd2
  } qmode_t;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       token_end;
    logic       text_done;
    logic       unclosed_quote;
    logic       last;
  } res_t;

  // what the step logic hands to the result queue
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  // queue status toward the top level
  typedef struct packed {
    logic           space2;
    logic [QAW:0]   count;
  } qstat_t;

  typedef struct packed {
    qmode_t qm;
    logic   tok;
    logic   bsp;
    logic   emit;
    res_t   res;
  } plain_t;

  function automatic logic is_ws(input logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  endfunction

  function automatic res_t char_res(input logic [7:0] c);
    res_t r;
    r = '0;
    r.ch = c;
    r.has_char = 1'b1;
    return r;
  endfunction

  // one byte with no backslash held
  function automatic plain_t plain_byte(input qmode_t qm, input logic tok,
                                        input logic [7:0] c);
    plain_t p;
    logic [7:0] closer;
    p = '0;
    p.qm = qm;
    p.tok = tok;
    closer = (qm == QM_SINGLE) ? CH_SQ : CH_DQ;
    if (qm != QM_NONE) begin
      p.tok = 1'b1;
      if (c == closer) begin
        p.qm = QM_NONE;
      end else if ((c == CH_BSL) && (qm == QM_DOUBLE)) begin
        p.bsp = 1'b1;
      end else begin
        p.emit = 1'b1;
        p.res = char_res(c);
      end
    end else if (c == CH_SQ) begin
      p.qm = QM_SINGLE;
      p.tok = 1'b1;
    end else if (c == CH_DQ) begin
      p.qm = QM_DOUBLE;
      p.tok = 1'b1;
    end else if (is_ws(c)) begin
      if (tok) begin
        p.emit = 1'b1;
        p.res.token_end = 1'b1;
        p.tok = 1'b0;
      end
    end else if (c == CH_BSL) begin
      p.bsp = 1'b1;
      p.tok = 1'b1;
    end else begin
      p.emit = 1'b1;
      p.res = char_res(c);
      p.tok = 1'b1;
    end
    return p;
  endfunction

endpackage

[rtl/qat_core.sv]
module qat_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              op,
  input  logic [7:0]        ch,
  output qat_pkg::push_t    push
);
  import qat_pkg::*;

  qmode_t qm_r, qm_nxt;
  logic   tok_r, tok_nxt;
  logic   bsp_r, bsp_nxt;

  plain_t p;
  logic   a_vld, b_vld;
  res_t   a_res, b_res;
  logic   escaped;

  always_comb begin
    qm_nxt = qm_r;
    tok_nxt = tok_r;
    bsp_nxt = bsp_r;
    a_vld = 1'b0;
    b_vld = 1'b0;
    a_res = '0;
    b_res = '0;
    escaped = 1'b0;
    p = plain_byte(qm_r, bsp_r ? 1'b1 : tok_r, ch);
    if (op == OP_END) begin
      // held backslash goes out as a literal first
      if (bsp_r) begin
        a_vld = 1'b1;
        a_res = char_res(CH_BSL);
      end
      b_vld = 1'b1;
      b_res.text_done = 1'b1;
      if (qm_r != QM_NONE) begin
        b_res.unclosed_quote = 1'b1;
      end else if (tok_r || bsp_r) begin
        b_res.token_end = 1'b1;
      end
      qm_nxt = QM_NONE;
      tok_nxt = 1'b0;
      bsp_nxt = 1'b0;
    end else if (bsp_r) begin
      if (qm_r == QM_DOUBLE) begin
        escaped = (ch == CH_DQ);
      end else begin
        escaped = is_ws(ch) || (ch == CH_SQ) || (ch == CH_DQ);
      end
      if (escaped) begin
        a_vld = 1'b1;
        a_res = char_res(ch);
        bsp_nxt = 1'b0;
        tok_nxt = 1'b1;
      end else begin
        a_vld = 1'b1;
        a_res = char_res(CH_BSL);
        b_vld = p.emit;
        b_res = p.res;
        qm_nxt = p.qm;
        tok_nxt = p.tok;
        bsp_nxt = p.bsp;
      end
    end else begin
      b_vld = p.emit;
      b_res = p.res;
      qm_nxt = p.qm;
      tok_nxt = p.tok;
      bsp_nxt = p.bsp;
    end

    // pack results in order, flag the final one
    push = '0;
    if (a_vld && b_vld) begin
      push.num = 2'd2;
      push.r0 = a_res;
      push.r1 = b_res;
      push.r1.last = 1'b1;
    end else if (a_vld) begin
      push.num = 2'd1;
      push.r0 = a_res;
      push.r0.last = 1'b1;
    end else if (b_vld) begin
      push.num = 2'd1;
      push.r0 = b_res;
      push.r0.last = 1'b1;
    end
    if (!step) begin
      push.num = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r <= QM_NONE;
      tok_r <= 1'b0;
      bsp_r <= 1'b0;
    end else if (step) begin
      qm_r <= qm_nxt;
      tok_r <= tok_nxt;
      bsp_r <= bsp_nxt;
    end
  end

endmodule

[rtl/qat_resq.sv]
module qat_resq (
  input  logic              clk,
  input  logic              rst_n,
  input  qat_pkg::push_t    push,
  input  logic              pop,
  output qat_pkg::res_t     head,
  output logic              head_vld,
  output qat_pkg::qstat_t   stat
);
  import qat_pkg::*;

  res_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_r, wr_nxt;
  logic [QAW-1:0]   rd_r, rd_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic [QAW-1:0]   wr1;

  assign wr1 = wr_r + QAW'(1);
  assign head = mem_r[rd_r];
  assign head_vld = (cnt_r != '0);
  assign stat.count = cnt_r;
  assign stat.space2 = (cnt_r <= (QAW+1)'(QDEPTH - 2));

  always_comb begin
    wr_nxt = wr_r + QAW'(push.num);
    rd_nxt = rd_r + QAW'(pop);
    cnt_nxt = cnt_r + (QAW+1)'(push.num) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr1] <= push.r1;
    end
  end

endmodule

[rtl/quoted_argument_tokenizer.sv]
// throughput: one input transaction per cycle while the result queue has room for
//   two results; a transaction that yields two results (held backslash given back
//   as a literal) sends them out one after the other
// the rate is set by the single output port of the four-entry result queue
// reset: synchronous, active low; clears the input stage, the quote/token/backslash
//   state and the result queue, so no result is pending after reset
module quoted_argument_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_has_char,
  output logic        out_token_end,
  output logic        out_text_done,
  output logic        out_unclosed_quote,
  output logic        out_last
);
  import qat_pkg::*;

  // input register
  logic       vld_r;
  logic       op_r;
  logic [7:0] ch_r;

  logic    step;
  logic    pop;
  push_t   push;
  res_t    head;
  logic    head_vld;
  qstat_t  qstat;

  // the held transaction moves on when the queue can absorb two results
  assign step = vld_r && qstat.space2;
  assign in_stall = vld_r && !qstat.space2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      op_r <= in_op;
      ch_r <= in_char_in;
    end
  end

  // tokenizer state and per-byte decision
  qat_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .op    (op_r),
    .ch    (ch_r),
    .push  (push)
  );

  // results wait here so the input side keeps moving under output stall
  qat_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .head_vld (head_vld),
    .stat     (qstat)
  );

  assign pop = head_vld && !out_stall;

  assign out_valid          = head_vld;
  assign out_char           = head.ch;
  assign out_has_char       = head.has_char;
  assign out_token_end      = head.token_end;
  assign out_text_done      = head.text_done;
  assign out_unclosed_quote = head.unclosed_quote;
  assign out_last           = head.last;

  // queue never holds more than its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= (QAW+1)'(QDEPTH))
    else $error("result queue overfilled");

  // a step only happens with room for two results
  assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (qstat.count <= (QAW+1)'(QDEPTH - 2)))
    else $error("step without queue space");

  // end of text is always the final result of its transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_done) |-> out_last)
    else $error("text done result not last");

  // a result carries a byte or a marker, never both
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_char) |-> (!out_token_end && !out_text_done))
    else $error("byte result carries a marker");

endmodule
